@@ rtl/core/ffha_pkg.sv @@
// Shared constants, codes and item type for the first-fit heap allocator.
package ffha_pkg;

	localparam int HEAP_BYTES_DEF   = 1048576;
	localparam int MAX_BLOCKS_DEF   = 256;
	localparam int HEADER_BYTES_DEF = 32;

	localparam int ADDR_W    = 48;
	localparam int REQ_W     = 21;
	localparam int RS_W      = 22;
	localparam int GRANT_W   = 20;
	localparam int LIVE_W    = 9;
	localparam int ALIGN     = 16;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ZERO    = 3'd1,
		ST_OOM     = 3'd2,
		ST_INVALID = 3'd3,
		ST_DOUBLE  = 3'd4,
		ST_NULL    = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OP_ALLOC,
		OP_ZERO,
		OP_FREE,
		OP_NULL
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [RS_W-1:0]   rs;
		logic [ADDR_W-1:0] addr;
	} item_t;

endpackage

@@ rtl/core/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator with coalescing.
// Zero-size and null items go from the queue straight to the result state; other items
// search the block table and may then shift it to insert or remove entries.
// Flow: the back end handles one item at a time, set by the sequential block
// table walk; the two-entry queue holds up to two further items.
// Reset: asynchronous, active low; the table holds one free block spanning the heap.
module first_fit_heap_allocator
	import ffha_pkg::*;
#(
	parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [ADDR_W-1:0]  cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               cmd,
	input  logic [REQ_W-1:0]   req_bytes,
	input  logic [ADDR_W-1:0]  free_address,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [ADDR_W-1:0]  data_address,
	output logic [GRANT_W-1:0] granted_bytes,
	output logic [GRANT_W-1:0] bytes_in_use,
	output logic [LIVE_W-1:0]  live_allocations
);

	logic  q_full;
	logic  push;
	item_t push_item;
	logic  pop;
	logic  q_valid;
	item_t q_item;

	assign cfg_ready = 1'b1;

	ffha_front u_front (
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.req_bytes    (req_bytes),
		.free_address (free_address),
		.q_full       (q_full),
		.push         (push),
		.push_item    (push_item)
	);

	ffha_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.pop_valid (q_valid),
		.pop_item  (q_item)
	);

	ffha_back #(
		.HEAP_BYTES   (HEAP_BYTES),
		.MAX_BLOCKS   (MAX_BLOCKS),
		.HEADER_BYTES (HEADER_BYTES)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_data         (cfg_data),
		.q_valid          (q_valid),
		.q_item           (q_item),
		.pop              (pop),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.data_address     (data_address),
		.granted_bytes    (granted_bytes),
		.bytes_in_use     (bytes_in_use),
		.live_allocations (live_allocations)
	);

endmodule

@@ rtl/core/ffha_front.sv @@
// Input side: accepts items, rounds request sizes and classifies the operation.
module ffha_front
	import ffha_pkg::*;
(
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cmd,
	input  logic [REQ_W-1:0]  req_bytes,
	input  logic [ADDR_W-1:0] free_address,
	input  logic              q_full,
	output logic              push,
	output item_t             push_item
);

	logic [RS_W-1:0] rounded;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign rounded  = (RS_W'(req_bytes) + RS_W'(ALIGN - 1)) & ~RS_W'(ALIGN - 1);

	always_comb begin
		push_item.rs   = rounded;
		push_item.addr = free_address;
		if (!cmd) begin
			push_item.op = (req_bytes == '0) ? OP_ZERO : OP_ALLOC;
		end else begin
			push_item.op = (free_address == '0) ? OP_NULL : OP_FREE;
		end
	end

endmodule

@@ rtl/core/ffha_queue.sv @@
// Two-entry item queue between the front and the back.
module ffha_queue
	import ffha_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  pop_valid,
	output item_t pop_item
);

	item_t       slot_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  fill_q;

	assign full      = (fill_q == 2'd2);
	assign pop_valid = (fill_q != 2'd0);
	assign pop_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			fill_q <= fill_q + 2'(push) - 2'(pop);
		end
	end

endmodule

@@ rtl/core/ffha_back.sv @@
// Execution side: block table memory, first-fit search, split, coalesce and results.
module ffha_back
	import ffha_pkg::*;
#(
	parameter int HEAP_BYTES   = HEAP_BYTES_DEF,
	parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF,
	parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [ADDR_W-1:0]  cfg_data,
	input  logic               q_valid,
	input  item_t              q_item,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic [ADDR_W-1:0]  data_address,
	output logic [GRANT_W-1:0] granted_bytes,
	output logic [GRANT_W-1:0] bytes_in_use,
	output logic [LIVE_W-1:0]  live_allocations
);

	localparam int OFF_W = $clog2(HEAP_BYTES + 1);
	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
	localparam int CW    = ((OFF_W > RS_W) ? OFF_W : RS_W) + 2;
	localparam int SW    = CNT_W + 1;

	typedef struct packed {
		logic             fr;
		logic [OFF_W-1:0] size;
		logic [OFF_W-1:0] off;
	} entry_t;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_CHK, S_INS_RD, S_INS_WR, S_INS_NB, S_WR_CUR,
		S_RD_NX, S_CK_NX, S_RD_PV, S_CK_PV, S_FIN, S_RM_RD, S_RM_WR,
		S_RM_DONE, S_RES
	} state_t;

	localparam entry_t RESET_ENTRY = '{fr: 1'b1,
		size: OFF_W'(HEAP_BYTES - HEADER_BYTES), off: '0};

	entry_t mem [MAX_BLOCKS];
	entry_t mem_rd_q;
	logic   rd_zero_q;
	entry_t rd_entry;

	state_t            state_q;
	item_t             item_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  k_q;
	logic [1:0]        n_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [OFF_W-1:0]  used_q;
	logic [CNT_W-1:0]  alloc_q;
	logic [ADDR_W-1:0] base_q;
	logic              init_q;
	entry_t            cur_q;
	entry_t            nb_q;
	entry_t            prev_q;
	logic              mrg_nx_q;
	logic              mrg_pv_q;
	status_t           res_status_q;
	logic [ADDR_W-1:0] res_data_q;
	logic [OFF_W-1:0]  res_granted_q;

	logic              out_valid_q;
	status_t           out_status_q;
	logic [ADDR_W-1:0] out_data_q;
	logic [GRANT_W-1:0] out_granted_q;
	logic [GRANT_W-1:0] out_used_q;
	logic [LIVE_W-1:0] out_live_q;

	logic              we;
	logic [IDX_W-1:0]  waddr;
	entry_t            wdata;
	logic [IDX_W-1:0]  raddr;

	logic              fit;
	logic              split;
	logic [ADDR_W-1:0] da;
	logic              addr_hit;
	logic [OFF_W-1:0]  grant_sz;
	logic [CNT_W-1:0]  rm_k;
	logic [1:0]        rm_n;
	logic [CNT_W-1:0]  k_dec;
	logic [CNT_W-1:0]  pos_inc;
	logic [CNT_W-1:0]  pos_dec;
	logic [SW-1:0]     rm_src;

	assign rd_entry = (rd_zero_q && init_q) ? RESET_ENTRY : mem_rd_q;
	assign pop      = (state_q == S_IDLE) && q_valid;

	assign fit      = rd_entry.fr && (CW'(rd_entry.size) >= CW'(item_q.rs));
	assign split    = (CW'(rd_entry.size) >= CW'(item_q.rs) + CW'(HEADER_BYTES + ALIGN))
		&& (cnt_q < CNT_W'(MAX_BLOCKS));
	assign grant_sz = split ? OFF_W'(item_q.rs) : rd_entry.size;
	assign da       = base_q + ADDR_W'(rd_entry.off) + ADDR_W'(HEADER_BYTES);
	assign addr_hit = (da == item_q.addr);
	assign rm_k     = mrg_pv_q ? pos_q : pos_q + CNT_W'(1);
	assign rm_n     = (mrg_pv_q && mrg_nx_q) ? 2'd2 : 2'd1;
	assign k_dec    = k_q - CNT_W'(1);
	assign pos_inc  = pos_q + CNT_W'(1);
	assign pos_dec  = pos_q - CNT_W'(1);
	assign rm_src   = SW'(k_q) + SW'(n_q);

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = cur_q;
		raddr = '0;
		unique case (state_q)
			S_RD:      raddr = idx_q[IDX_W-1:0];
			S_INS_RD:  raddr = k_dec[IDX_W-1:0];
			S_INS_WR: begin
				we    = 1'b1;
				waddr = k_q[IDX_W-1:0];
				wdata = rd_entry;
			end
			S_INS_NB: begin
				we    = 1'b1;
				waddr = pos_inc[IDX_W-1:0];
				wdata = nb_q;
			end
			S_WR_CUR: begin
				we    = 1'b1;
				waddr = pos_q[IDX_W-1:0];
				wdata = cur_q;
			end
			S_RD_NX:   raddr = pos_inc[IDX_W-1:0];
			S_RD_PV:   raddr = pos_dec[IDX_W-1:0];
			S_FIN: begin
				we = 1'b1;
				if (mrg_pv_q) begin
					waddr = pos_dec[IDX_W-1:0];
					wdata = prev_q;
				end else begin
					waddr = pos_q[IDX_W-1:0];
					wdata = cur_q;
				end
			end
			S_RM_RD:   raddr = rm_src[IDX_W-1:0];
			S_RM_WR: begin
				we    = 1'b1;
				waddr = k_q[IDX_W-1:0];
				wdata = rd_entry;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		mem_rd_q  <= mem[raddr];
		rd_zero_q <= (raddr == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= CNT_W'(1);
			used_q        <= '0;
			alloc_q       <= '0;
			base_q        <= '0;
			init_q        <= 1'b1;
			out_valid_q   <= 1'b0;
			item_q        <= '0;
			idx_q         <= '0;
			pos_q         <= '0;
			k_q           <= '0;
			n_q           <= '0;
			cur_q         <= '0;
			nb_q          <= '0;
			prev_q        <= '0;
			mrg_nx_q      <= 1'b0;
			mrg_pv_q      <= 1'b0;
			res_status_q  <= ST_OK;
			res_data_q    <= '0;
			res_granted_q <= '0;
			out_status_q  <= ST_OK;
			out_data_q    <= '0;
			out_granted_q <= '0;
			out_used_q    <= '0;
			out_live_q    <= '0;
		end else begin
			if (cfg_valid) begin
				base_q <= cfg_data;
			end
			if (we && waddr == '0) begin
				init_q <= 1'b0;
			end
			if (out_valid_q && !out_stall && state_q != S_RES) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						item_q        <= q_item;
						idx_q         <= '0;
						res_data_q    <= '0;
						res_granted_q <= '0;
						unique case (q_item.op)
							OP_ZERO: begin
								res_status_q <= ST_ZERO;
								state_q      <= S_RES;
							end
							OP_NULL: begin
								res_status_q <= ST_NULL;
								state_q      <= S_RES;
							end
							default: state_q <= S_RD;
						endcase
					end
				end
				S_RD: begin
					if (idx_q == cnt_q) begin
						res_status_q <= (item_q.op == OP_ALLOC) ? ST_OOM : ST_INVALID;
						state_q      <= S_RES;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					pos_q <= idx_q;
					if (item_q.op == OP_ALLOC) begin
						if (fit) begin
							res_status_q  <= ST_OK;
							res_data_q    <= da;
							res_granted_q <= grant_sz;
							cur_q         <= '{fr: 1'b0, size: grant_sz, off: rd_entry.off};
							used_q        <= used_q + grant_sz;
							alloc_q       <= alloc_q + CNT_W'(1);
							nb_q          <= '{fr: 1'b1,
								size: rd_entry.size - OFF_W'(item_q.rs) - OFF_W'(HEADER_BYTES),
								off: rd_entry.off + OFF_W'(HEADER_BYTES) + OFF_W'(item_q.rs)};
							k_q           <= cnt_q;
							if (!split) begin
								state_q <= S_WR_CUR;
							end else if (SW'(cnt_q) >= SW'(idx_q) + SW'(2)) begin
								state_q <= S_INS_RD;
							end else begin
								state_q <= S_INS_NB;
							end
						end else begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= S_RD;
						end
					end else begin
						if (!addr_hit) begin
							idx_q   <= idx_q + CNT_W'(1);
							state_q <= S_RD;
						end else if (rd_entry.fr) begin
							res_status_q <= ST_DOUBLE;
							state_q      <= S_RES;
						end else begin
							res_status_q  <= ST_OK;
							res_granted_q <= rd_entry.size;
							cur_q         <= '{fr: 1'b1, size: rd_entry.size, off: rd_entry.off};
							used_q        <= (used_q >= rd_entry.size) ? used_q - rd_entry.size : '0;
							if (alloc_q != '0) begin
								alloc_q <= alloc_q - CNT_W'(1);
							end
							mrg_nx_q <= 1'b0;
							mrg_pv_q <= 1'b0;
							if (SW'(idx_q) + SW'(1) < SW'(cnt_q)) begin
								state_q <= S_RD_NX;
							end else if (idx_q != '0) begin
								state_q <= S_RD_PV;
							end else begin
								state_q <= S_FIN;
							end
						end
					end
				end
				S_INS_RD: state_q <= S_INS_WR;
				S_INS_WR: begin
					k_q <= k_q - CNT_W'(1);
					if (SW'(k_q) >= SW'(pos_q) + SW'(3)) begin
						state_q <= S_INS_RD;
					end else begin
						state_q <= S_INS_NB;
					end
				end
				S_INS_NB: begin
					cnt_q   <= cnt_q + CNT_W'(1);
					state_q <= S_WR_CUR;
				end
				S_WR_CUR: state_q <= S_RES;
				S_RD_NX:  state_q <= S_CK_NX;
				S_CK_NX: begin
					if (rd_entry.fr) begin
						cur_q.size <= cur_q.size + OFF_W'(HEADER_BYTES) + rd_entry.size;
						mrg_nx_q   <= 1'b1;
					end
					state_q <= (pos_q != '0) ? S_RD_PV : S_FIN;
				end
				S_RD_PV: state_q <= S_CK_PV;
				S_CK_PV: begin
					if (rd_entry.fr) begin
						prev_q   <= '{fr: 1'b1,
							size: rd_entry.size + OFF_W'(HEADER_BYTES) + cur_q.size,
							off: rd_entry.off};
						mrg_pv_q <= 1'b1;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					k_q <= rm_k;
					n_q <= rm_n;
					if (!mrg_pv_q && !mrg_nx_q) begin
						state_q <= S_RES;
					end else if (SW'(rm_k) + SW'(rm_n) < SW'(cnt_q)) begin
						state_q <= S_RM_RD;
					end else begin
						state_q <= S_RM_DONE;
					end
				end
				S_RM_RD: state_q <= S_RM_WR;
				S_RM_WR: begin
					k_q <= k_q + CNT_W'(1);
					if (SW'(k_q) + SW'(1) + SW'(n_q) < SW'(cnt_q)) begin
						state_q <= S_RM_RD;
					end else begin
						state_q <= S_RM_DONE;
					end
				end
				S_RM_DONE: begin
					cnt_q   <= cnt_q - CNT_W'(n_q);
					state_q <= S_RES;
				end
				S_RES: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						out_status_q  <= res_status_q;
						out_data_q    <= res_data_q;
						out_granted_q <= GRANT_W'(res_granted_q);
						out_used_q    <= GRANT_W'(used_q);
						out_live_q    <= LIVE_W'(alloc_q);
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid        = out_valid_q;
	assign status           = out_status_q;
	assign data_address     = out_data_q;
	assign granted_bytes    = out_granted_q;
	assign bytes_in_use     = out_used_q;
	assign live_allocations = out_live_q;

endmodule

@@ rtl/core/ffha_checker.sv @@
// Port-level checker for the first-fit heap allocator, bound to the top level.
module ffha_checker
	import ffha_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [2:0]         status,
	input logic [ADDR_W-1:0]  data_address,
	input logic [GRANT_W-1:0] granted_bytes,
	input logic [GRANT_W-1:0] bytes_in_use,
	input logic [LIVE_W-1:0]  live_allocations
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(data_address)
			&& $stable(granted_bytes) && $stable(bytes_in_use)
			&& $stable(live_allocations))
		else $error("result changed while stalled");

	a_fail_no_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> data_address == '0)
		else $error("address on failed item");

	a_fail_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> granted_bytes == '0)
		else $error("grant on failed item");

	a_ok_grant: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_OK |-> granted_bytes != '0)
		else $error("empty grant on ok item");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (.*);

@@ bench/first_fit_heap_allocator_test.sv @@
// Self-checking testbench for the first-fit heap allocator: directed table plus random traffic.
`timescale 1ns / 1ps
module first_fit_heap_allocator_test;
	import ffha_pkg::*;

	localparam int HEAP  = HEAP_BYTES_DEF;
	localparam int MAXB  = MAX_BLOCKS_DEF;
	localparam int HDR   = HEADER_BYTES_DEF;
	localparam logic ALLOC_CMD = 1'b0;
	localparam logic FREE_CMD  = 1'b1;

	typedef struct {
		logic [2:0]         status;
		logic [ADDR_W-1:0]  data_address;
		logic [GRANT_W-1:0] granted_bytes;
		logic [GRANT_W-1:0] bytes_in_use;
		logic [LIVE_W-1:0]  live_allocations;
	} reply_t;

	typedef struct {
		logic               cmd;
		logic [REQ_W-1:0]   req;
		logic [ADDR_W-1:0]  addr;
		bit                 has_expect;
		status_t            exp_status;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [ADDR_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic cmd = 0;
	logic [REQ_W-1:0] req_bytes = '0;
	logic [ADDR_W-1:0] free_address = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] status;
	logic [ADDR_W-1:0] data_address;
	logic [GRANT_W-1:0] granted_bytes;
	logic [GRANT_W-1:0] bytes_in_use;
	logic [LIVE_W-1:0] live_allocations;

	first_fit_heap_allocator dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.cmd(cmd), .req_bytes(req_bytes), .free_address(free_address),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .data_address(data_address), .granted_bytes(granted_bytes),
		.bytes_in_use(bytes_in_use), .live_allocations(live_allocations)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// allocator shadow state
	longint unsigned blk_off[MAXB];
	longint unsigned blk_size[MAXB];
	bit blk_free[MAXB];
	int n_blocks;
	longint unsigned used_bytes;
	int live_count;
	logic [ADDR_W-1:0] base_addr;

	reply_t pending_replies[$];
	logic [ADDR_W-1:0] live_addrs[$];
	int errors = 0;
	bit hold_off = 0;
	bit bursty = 1;

	task automatic shadow_reset();
		n_blocks = 1;
		blk_off[0] = 0;
		blk_size[0] = HEAP - HDR;
		blk_free[0] = 1;
		used_bytes = 0;
		live_count = 0;
		base_addr = '0;
	endtask

	task automatic drop_block(int idx);
		for (int k = idx; k + 1 < n_blocks; k++) begin
			blk_off[k] = blk_off[k+1];
			blk_size[k] = blk_size[k+1];
			blk_free[k] = blk_free[k+1];
		end
		n_blocks--;
	endtask

	function automatic logic [ADDR_W-1:0] data_start(int idx);
		return ADDR_W'(base_addr + blk_off[idx] + HDR);
	endfunction

	task automatic heap_apply(input logic c, input logic [REQ_W-1:0] rq,
			input logic [ADDR_W-1:0] ad, output reply_t r);
		longint unsigned rs;
		int i;
		bit hit;
		r.status = ST_OK;
		r.data_address = '0;
		r.granted_bytes = '0;
		hit = 0;
		if (c == ALLOC_CMD) begin
			if (rq == 0) begin
				r.status = ST_ZERO;
			end else begin
				rs = (longint'(rq) + 15) & ~64'd15;
				for (i = 0; i < n_blocks; i++) begin
					if (blk_free[i] && blk_size[i] >= rs) begin
						hit = 1;
						break;
					end
				end
				if (!hit) begin
					r.status = ST_OOM;
				end else begin
					if (blk_size[i] >= rs + HDR + 16 && n_blocks < MAXB) begin
						for (int k = n_blocks; k > i + 1; k--) begin
							blk_off[k] = blk_off[k-1];
							blk_size[k] = blk_size[k-1];
							blk_free[k] = blk_free[k-1];
						end
						blk_off[i+1] = blk_off[i] + HDR + rs;
						blk_size[i+1] = blk_size[i] - rs - HDR;
						blk_free[i+1] = 1;
						blk_size[i] = rs;
						n_blocks++;
					end
					blk_free[i] = 0;
					used_bytes += blk_size[i];
					live_count++;
					r.data_address = data_start(i);
					r.granted_bytes = GRANT_W'(blk_size[i]);
					live_addrs.push_back(data_start(i));
				end
			end
		end else if (ad == 0) begin
			r.status = ST_NULL;
		end else begin
			for (i = 0; i < n_blocks; i++) begin
				if (data_start(i) == ad) begin
					hit = 1;
					break;
				end
			end
			if (!hit) begin
				r.status = ST_INVALID;
			end else if (blk_free[i]) begin
				r.status = ST_DOUBLE;
			end else begin
				r.granted_bytes = GRANT_W'(blk_size[i]);
				blk_free[i] = 1;
				used_bytes = (used_bytes >= blk_size[i]) ? used_bytes - blk_size[i] : 0;
				if (live_count > 0)
					live_count--;
				if (i + 1 < n_blocks && blk_free[i+1]) begin
					blk_size[i] += HDR + blk_size[i+1];
					drop_block(i + 1);
				end
				if (i > 0 && blk_free[i-1]) begin
					blk_size[i-1] += HDR + blk_size[i];
					drop_block(i);
				end
			end
		end
		r.bytes_in_use = GRANT_W'(used_bytes);
		r.live_allocations = LIVE_W'(live_count);
	endtask

	function automatic int gap_len();
		if (!bursty)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(10, 60);
		return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
	endfunction

	task automatic send_item(input logic c, input logic [REQ_W-1:0] rq,
			input logic [ADDR_W-1:0] ad, input bit chk, input status_t want);
		reply_t r;
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1;
		cmd <= c;
		req_bytes <= rq;
		free_address <= ad;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		heap_apply(c, rq, ad, r);
		if (chk && r.status != want) begin
			$error("table row status: expected %0d, actual %0d", want, r.status);
			errors++;
		end
		pending_replies.push_back(r);
	endtask

	task automatic write_base(input logic [ADDR_W-1:0] v);
		in_valid <= 0;
		wait (pending_replies.size() == 0);
		repeat (1100) @(posedge clk);
		cfg_valid <= 1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
		base_addr = v;
	endtask

	task automatic free_live(input bit anyone);
		int k;
		logic [ADDR_W-1:0] a;
		if (live_addrs.size() == 0) begin
			send_item(FREE_CMD, REQ_W'($urandom), {$urandom, $urandom}, 0, ST_OK);
			return;
		end
		k = anyone ? $urandom_range(0, live_addrs.size() - 1) : 0;
		a = live_addrs[k];
		live_addrs.delete(k);
		send_item(FREE_CMD, REQ_W'($urandom), a, 0, ST_OK);
	endtask

	task automatic random_phase(int count, int alloc_bias);
		int sel;
		for (int n = 0; n < count; n++) begin
			sel = $urandom_range(0, 99);
			if (sel < alloc_bias) begin
				if ($urandom_range(0, 9) == 0)
					send_item(ALLOC_CMD, REQ_W'($urandom), ADDR_W'($urandom), 0, ST_OK);
				else
					send_item(ALLOC_CMD, REQ_W'($urandom_range(1, 600)),
						{$urandom, $urandom}, 0, ST_OK);
			end else if (sel < 92) begin
				free_live(1);
			end else if (sel < 95) begin
				send_item(FREE_CMD, REQ_W'($urandom), {$urandom, $urandom}, 0, ST_OK);
			end else if (sel < 97) begin
				send_item(FREE_CMD, REQ_W'($urandom), '0, 0, ST_OK);
			end else begin
				send_item(FREE_CMD, REQ_W'($urandom),
					ADDR_W'(base_addr + HDR + 16 * $urandom_range(0, 200)), 0, ST_OK);
			end
		end
	endtask

	row_t rows[$];

	task automatic add_row(logic c, logic [REQ_W-1:0] rq, logic [ADDR_W-1:0] ad,
			bit chk, status_t st);
		row_t w;
		w.cmd = c;
		w.req = rq;
		w.addr = ad;
		w.has_expect = chk;
		w.exp_status = st;
		rows.push_back(w);
	endtask

	initial begin
		shadow_reset();
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		add_row(ALLOC_CMD, '0, '0, 1, ST_ZERO);
		add_row(FREE_CMD, '0, '0, 1, ST_NULL);
		add_row(FREE_CMD, '0, 48'd32, 1, ST_DOUBLE);
		add_row(FREE_CMD, '0, '1, 1, ST_INVALID);
		add_row(ALLOC_CMD, 21'h1FFFFF, '1, 1, ST_OOM);
		add_row(ALLOC_CMD, 21'd1048576, '0, 1, ST_OOM);
		add_row(ALLOC_CMD, 21'd1, '0, 1, ST_OK);
		add_row(ALLOC_CMD, 21'd16, '0, 1, ST_OK);
		add_row(ALLOC_CMD, 21'd17, '0, 1, ST_OK);
		add_row(FREE_CMD, '0, 48'd80, 1, ST_OK);
		add_row(FREE_CMD, '0, 48'd80, 1, ST_DOUBLE);
		add_row(FREE_CMD, '0, 48'd40, 1, ST_INVALID);
		add_row(FREE_CMD, '0, 48'd32, 1, ST_OK);
		add_row(FREE_CMD, '0, 48'd128, 1, ST_OK);
		add_row(FREE_CMD, '0, 48'd80, 1, ST_INVALID);
		add_row(ALLOC_CMD, 21'd1048512, '0, 0, ST_OK);
		add_row(ALLOC_CMD, 21'd1048544, '0, 1, ST_OOM);
		add_row(FREE_CMD, '0, 48'd32, 0, ST_OK);
		add_row(ALLOC_CMD, 21'd1048544, '0, 1, ST_OK);
		add_row(FREE_CMD, '0, 48'd32, 1, ST_OK);
		foreach (rows[k])
			send_item(rows[k].cmd, rows[k].req, rows[k].addr, rows[k].has_expect,
				rows[k].exp_status);

		write_base('1);
		send_item(ALLOC_CMD, 21'd100, '0, 0, ST_OK);
		send_item(ALLOC_CMD, 21'd5, '0, 0, ST_OK);
		free_live(0);
		free_live(0);

		write_base(48'h8000_0000_1230);
		random_phase(250, 60);

		// fill the table until splitting stops
		write_base('0);
		while (live_addrs.size() > 0)
			free_live(1);
		hold_off = 1;
		for (int n = 0; n < 270; n++)
			send_item(ALLOC_CMD, REQ_W'($urandom_range(1, 48)), '0, 0, ST_OK);
		random_phase(60, 30);

		write_base({$urandom, $urandom});
		bursty = 0;
		random_phase(80, 55);
		bursty = 1;
		random_phase(150, 55);

		in_valid <= 0;
		wait (pending_replies.size() == 0);
		repeat (1100) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		out_stall <= 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				hold_off = 0;
				out_stall <= 1;
				repeat (400) @(posedge clk);
				out_stall <= 0;
			end else if (bursty && $urandom_range(0, 3) == 0) begin
				out_stall <= 1;
				repeat (($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
						: $urandom_range(1, 3)) @(posedge clk);
				out_stall <= 0;
			end
		end
	end

	always @(posedge clk) begin
		reply_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				$error("unexpected result: status %0d", status);
				errors++;
			end else begin
				e = pending_replies.pop_front();
				if (status !== e.status) begin
					$error("status: expected %0d, actual %0d", e.status, status);
					errors++;
				end
				if (data_address !== e.data_address) begin
					$error("data_address: expected %h, actual %h", e.data_address,
						data_address);
					errors++;
				end
				if (granted_bytes !== e.granted_bytes) begin
					$error("granted_bytes: expected %0d, actual %0d", e.granted_bytes,
						granted_bytes);
					errors++;
				end
				if (bytes_in_use !== e.bytes_in_use) begin
					$error("bytes_in_use: expected %0d, actual %0d", e.bytes_in_use,
						bytes_in_use);
					errors++;
				end
				if (live_allocations !== e.live_allocations) begin
					$error("live_allocations: expected %0d, actual %0d",
						e.live_allocations, live_allocations);
					errors++;
				end
			end
		end
	end

	initial begin
		#60ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
